// ===== sv/afbt_pkg.sv =====
// ----------------------------------------------------------------------------
// afbt_pkg
// Shared types, constants and register codes for the anchor backoff table.
// ----------------------------------------------------------------------------
package afbt_pkg;

  localparam int MAX_ANCHORS_DEF = 16;

  localparam int IDX_W    = 4;
  localparam int STREAK_W = 8;
  localparam int SKIP_W   = 8;
  localparam int MULT_W   = 4;
  localparam int GOOD_W   = 5;
  localparam int CNT_W    = 5;
  localparam int THR_W    = 8;
  localparam int BASE_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [MULT_W-1:0]   MULT_ONE = MULT_W'(1);
  localparam logic [MULT_W-1:0]   MULT_CAP = MULT_W'(8);
  localparam logic [STREAK_W-1:0] STREAK_MAX = '1;
  localparam logic [GOOD_W-1:0]   GOOD_MAX = '1;

  localparam logic [CNT_W-1:0]  RST_ANCHOR_COUNT = CNT_W'(16);
  localparam logic [THR_W-1:0]  RST_FAIL_THR     = THR_W'(3);
  localparam logic [BASE_W-1:0] RST_BASE_SKIP    = BASE_W'(2);
  localparam logic [SKIP_W-1:0] RST_MAX_SKIP     = SKIP_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANCHOR_COUNT = 2'd0,
    REG_FAIL_THR     = 2'd1,
    REG_BASE_SKIP    = 2'd2,
    REG_MAX_SKIP     = 2'd3
  } afbt_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOOK = 1'b1
  } afbt_state_t;

  typedef struct packed {
    logic [STREAK_W-1:0] streak;
    logic [SKIP_W-1:0]   skip;
    logic [MULT_W-1:0]   mult;
  } afbt_entry_t;

  localparam int ENTRY_W = $bits(afbt_entry_t);

  localparam afbt_entry_t ENTRY_RST = '{streak: '0, skip: '0, mult: MULT_ONE};

  typedef struct packed {
    logic [THR_W-1:0]  fail_threshold;
    logic [BASE_W-1:0] base_skip;
    logic [SKIP_W-1:0] max_skip;
  } afbt_cfg_t;

  typedef struct packed {
    logic              index_error;
    logic [SKIP_W-1:0] skip_length;
    logic              backoff_started;
    logic              recovered;
    logic [GOOD_W-1:0] good_count;
    logic              slot_valid;
    logic              skipped;
  } afbt_result_t;

endpackage

// ===== sv/anchor_failure_backoff_table.sv =====
// ----------------------------------------------------------------------------
// anchor_failure_backoff_table
// Per-anchor capped exponential backoff for ranging slots, state in a RAM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid/s_tready    tdata: anchor_index, range_ok
//                                            tuser: sweep_start
//  m_*       out        m_tvalid/m_tready    tdata: one result per request
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  A request is taken in ST_IDLE, where the RAM read of its entry is issued,
//  and is updated and written back in ST_LOOK; no new request is taken until
//  it has left ST_LOOK. Reset clears the per-entry valid bits; an entry not
//  yet written reads as streak 0, skip 0, multiplier 1. A stalled output holds
//  the update cycle until the output register frees.
// ----------------------------------------------------------------------------
module anchor_failure_backoff_table import afbt_pkg::*; #(
  parameter int MAX_ANCHORS = MAX_ANCHORS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [3:0] anchor_index, [4] range_ok, [7:5] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] sweep_start
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] skipped, [1] slot_valid, [6:2] good_count, [7] recovered,
  // [8] backoff_started, [16:9] skip_length, [17] index_error, [23:18] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

  afbt_state_t state, state_next;

  logic [CNT_W-1:0]  anchor_count;
  afbt_cfg_t         cfg;
  logic [GOOD_W-1:0] sweep_good;
  logic [MAX_ANCHORS-1:0] valid;

  logic [IDX_W-1:0] idx_reg;
  logic             ok_reg;
  logic             start_reg;

  logic              accept;
  logic              out_free;
  logic              done;
  logic              ram_we;
  logic [AW-1:0]     addr_reg;
  logic [ENTRY_W-1:0] ram_rdata;
  afbt_entry_t       entry_rd;
  afbt_entry_t       entry_next;
  logic              idx_err;
  logic [GOOD_W-1:0] good_base;
  logic [GOOD_W-1:0] good_next;
  afbt_result_t      result;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign addr_reg  = AW'(idx_reg);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    done     = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_LOOK: done = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_count       <= RST_ANCHOR_COUNT;
      cfg.fail_threshold <= RST_FAIL_THR;
      cfg.base_skip      <= RST_BASE_SKIP;
      cfg.max_skip       <= RST_MAX_SKIP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ANCHOR_COUNT: anchor_count       <= cfg_data[CNT_W-1:0];
        REG_FAIL_THR:     cfg.fail_threshold <= cfg_data[THR_W-1:0];
        REG_BASE_SKIP:    cfg.base_skip      <= cfg_data[BASE_W-1:0];
        REG_MAX_SKIP:     cfg.max_skip       <= cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_reg   <= s_tdata[IDX_W-1:0];
      ok_reg    <= s_tdata[IDX_W];
      start_reg <= s_tuser;
    end
  end

  afbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ANCHORS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_reg),
    .wdata (entry_next),
    .re    (accept),
    .raddr (AW'(s_tdata[IDX_W-1:0])),
    .rdata (ram_rdata)
  );

  always_comb begin
    idx_err   = ({1'b0, idx_reg} >= anchor_count) || (32'(idx_reg) >= MAX_ANCHORS);
    entry_rd  = (!idx_err && valid[addr_reg]) ? afbt_entry_t'(ram_rdata) : ENTRY_RST;
    good_base = start_reg ? '0 : sweep_good;
    ram_we    = done && !idx_err;
  end

  afbt_update u_update (
    .entry       (entry_rd),
    .range_ok    (ok_reg),
    .index_error (idx_err),
    .good_base   (good_base),
    .cfg         (cfg),
    .entry_next  (entry_next),
    .good_next   (good_next),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      sweep_good <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (ram_we) begin
        valid[addr_reg] <= 1'b1;
      end
      if (done) begin
        sweep_good <= good_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= OUT_DATA_W'(result);
    end
  end

endmodule

// ===== sv/afbt_ram.sv =====
// ----------------------------------------------------------------------------
// afbt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module afbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/afbt_update.sv =====
// ----------------------------------------------------------------------------
// afbt_update
// Per-item update of one anchor entry and the sweep good count.
// ----------------------------------------------------------------------------
module afbt_update import afbt_pkg::*; (
  input  afbt_entry_t       entry,
  input  logic              range_ok,
  input  logic              index_error,
  input  logic [GOOD_W-1:0] good_base,
  input  afbt_cfg_t         cfg,
  output afbt_entry_t       entry_next,
  output logic [GOOD_W-1:0] good_next,
  output afbt_result_t      result
);

  logic [STREAK_W-1:0] streak_inc;
  logic [SKIP_W:0]     prod;
  logic [SKIP_W-1:0]   slen;
  logic                start_bo;

  always_comb begin
    streak_inc = (entry.streak == STREAK_MAX) ? entry.streak : entry.streak + 1'b1;
    prod       = (SKIP_W + 1)'(cfg.base_skip) * (SKIP_W + 1)'(entry.mult);
    slen       = (prod > {1'b0, cfg.max_skip}) ? cfg.max_skip : prod[SKIP_W-1:0];
    start_bo   = (streak_inc >= cfg.fail_threshold);

    entry_next = entry;
    good_next  = good_base;
    result     = '0;

    if (index_error) begin
      result.index_error = 1'b1;
    end else if (entry.skip != '0) begin
      entry_next.skip = entry.skip - 1'b1;
      result.skipped  = 1'b1;
    end else if (range_ok) begin
      result.recovered  = (entry.streak != '0);
      result.slot_valid = 1'b1;
      entry_next.streak = '0;
      entry_next.mult   = MULT_ONE;
      good_next = (good_base == GOOD_MAX) ? good_base : good_base + 1'b1;
    end else if (start_bo) begin
      entry_next.streak = '0;
      entry_next.skip   = slen;
      entry_next.mult   = (entry.mult < MULT_CAP) ? entry.mult << 1 : entry.mult;
      result.backoff_started = 1'b1;
      result.skip_length     = slen;
    end else begin
      entry_next.streak = streak_inc;
    end

    result.good_count = good_next;
  end

endmodule

// ===== sv/afbt_chk.sv =====
// ----------------------------------------------------------------------------
// afbt_chk
// Port-level checks on the result stream of the anchor backoff table.
// ----------------------------------------------------------------------------
module afbt_chk import afbt_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17] |-> m_tdata[16:7] == '0 && m_tdata[1:0] == '0)
    else $error("index error result carries other flags");

  a_skip_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1] == 1'b0 && m_tdata[8:7] == '0)
    else $error("skipped slot reported as ranged");

  a_len_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tdata[16:9] == '0)
    else $error("skip length without a backoff start");

endmodule

bind anchor_failure_backoff_table afbt_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/tb_anchor_failure_backoff_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_anchor_failure_backoff_table
// Self-checking bench for the per-anchor ranging backoff table. Ranging
// requests are streamed in as sweeps and noise under several register
// settings and stall patterns. A behavioral copy of the backoff table
// predicts each result, and results are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_anchor_failure_backoff_table;
  import afbt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int N_ANCH      = MAX_ANCHORS_DEF;

  typedef struct packed {
    logic [IDX_W-1:0] anchor;
    logic             range_ok;
    logic             sweep_start;
  } ranging_req_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  anchor_failure_backoff_table u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Behavioral copy of the table and its registers.
  logic [STREAK_W-1:0] streak_tbl [N_ANCH];
  logic [SKIP_W-1:0]   skip_tbl   [N_ANCH];
  logic [MULT_W-1:0]   mult_tbl   [N_ANCH];
  logic [GOOD_W-1:0]   good_cnt   = '0;
  logic [CNT_W-1:0]    anchors_in_use = RST_ANCHOR_COUNT;
  logic [THR_W-1:0]    fail_thr       = RST_FAIL_THR;
  logic [BASE_W-1:0]   base_skip      = RST_BASE_SKIP;
  logic [SKIP_W-1:0]   max_skip       = RST_MAX_SKIP;

  ranging_req_t pending_reqs [$];
  afbt_result_t slot_expect [$];
  ranging_req_t next_req;
  ranging_req_t seen_req;
  afbt_result_t got_res;
  afbt_result_t exp_res;
  logic         req_taken = 1'b0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           phase_anchors = N_ANCH;
  int           err_cnt = 0;
  int           cycle_cnt = 0;

  initial begin
    for (int i = 0; i < N_ANCH; i++) begin
      streak_tbl[i] = '0;
      skip_tbl[i]   = '0;
      mult_tbl[i]   = MULT_ONE;
    end
  end

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic afbt_result_t predict_slot(ranging_req_t req);
    afbt_result_t res;
    int unsigned  lim;
    int unsigned  span;
    int unsigned  a;
    res = '0;
    a = req.anchor;
    lim = (anchors_in_use < N_ANCH) ? anchors_in_use : N_ANCH;
    if (req.sweep_start) good_cnt = '0;
    if (a >= lim) begin
      res.index_error = 1'b1;
    end else if (skip_tbl[a] != '0) begin
      skip_tbl[a] = skip_tbl[a] - 1'b1;
      res.skipped = 1'b1;
    end else if (req.range_ok) begin
      res.recovered  = (streak_tbl[a] != '0);
      streak_tbl[a]  = '0;
      mult_tbl[a]    = MULT_ONE;
      res.slot_valid = 1'b1;
      if (good_cnt != GOOD_MAX) good_cnt = good_cnt + 1'b1;
    end else begin
      if (streak_tbl[a] != STREAK_MAX) streak_tbl[a] = streak_tbl[a] + 1'b1;
      if (streak_tbl[a] >= fail_thr) begin
        span = base_skip * mult_tbl[a];
        if (span > max_skip) span = max_skip;
        skip_tbl[a]   = SKIP_W'(span);
        streak_tbl[a] = '0;
        if (mult_tbl[a] < MULT_CAP) mult_tbl[a] = mult_tbl[a] << 1;
        res.backoff_started = 1'b1;
        res.skip_length     = SKIP_W'(span);
      end
    end
    res.good_count = good_cnt;
    return res;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // Monitor and scoreboard.
  always @(posedge clk) begin
    req_taken <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (afbt_reg_t'(cfg_index))
          REG_ANCHOR_COUNT: anchors_in_use = cfg_data[CNT_W-1:0];
          REG_FAIL_THR:     fail_thr = cfg_data[THR_W-1:0];
          REG_BASE_SKIP:    base_skip = cfg_data[BASE_W-1:0];
          REG_MAX_SKIP:     max_skip = cfg_data[SKIP_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        seen_req.anchor      = s_tdata[IDX_W-1:0];
        seen_req.range_ok    = s_tdata[IDX_W];
        seen_req.sweep_start = s_tuser;
        slot_expect.push_back(predict_slot(seen_req));
      end
      if (m_tvalid && m_tready) begin
        got_res = m_tdata[$bits(afbt_result_t)-1:0];
        if (slot_expect.size() == 0) begin
          $display("%0t: unexpected result expected none got %h", $time, got_res);
          err_cnt++;
        end else begin
          exp_res = slot_expect.pop_front();
          check_field("skipped", exp_res.skipped, got_res.skipped);
          check_field("slot_valid", exp_res.slot_valid, got_res.slot_valid);
          check_field("good_count", exp_res.good_count, got_res.good_count);
          check_field("recovered", exp_res.recovered, got_res.recovered);
          check_field("backoff_started", exp_res.backoff_started,
                      got_res.backoff_started);
          check_field("skip_length", exp_res.skip_length, got_res.skip_length);
          check_field("index_error", exp_res.index_error, got_res.index_error);
        end
      end
    end
  end

  // Request driver and result-side stalls.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!s_tvalid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= IN_DATA_W'({next_req.range_ok, next_req.anchor});
          s_tuser  <= next_req.sweep_start;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_anchor_failure_backoff_table failed");
      $finish;
    end
  end

  task automatic add_req(int a, bit ok, bit st);
    ranging_req_t r;
    r.anchor      = IDX_W'(a);
    r.range_ok    = ok;
    r.sweep_start = st;
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(afbt_reg_t r, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || slot_expect.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic setup_phase(int cnt, int thr, int base, int cap, idle_mode_t mode);
    write_reg(REG_ANCHOR_COUNT, CFG_DATA_W'(cnt));
    write_reg(REG_FAIL_THR, CFG_DATA_W'(thr));
    write_reg(REG_BASE_SKIP, CFG_DATA_W'(base));
    write_reg(REG_MAX_SKIP, CFG_DATA_W'(cap));
    @(negedge clk);
    cfg_valid <= 1'b0;
    phase_anchors = (cnt == 0 || cnt > N_ANCH) ? N_ANCH : cnt;
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 61; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 61; end
      default:   begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  // Mostly in-order sweeps over the active anchors, some cut short, with
  // random single requests mixed in.
  task automatic gen_traffic(int n, int fail_pct, int start_pct);
    int made;
    int cut;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 80) begin
        cut = ($urandom_range(9) == 0) ? $urandom_range(phase_anchors - 1)
                                        : phase_anchors - 1;
        for (int i = 0; i <= cut; i++) begin
          add_req(i, $urandom_range(99) >= fail_pct,
                  (i == 0) && ($urandom_range(99) < start_pct));
          made++;
        end
      end else begin
        add_req($urandom_range(N_ANCH - 1), $urandom_range(1),
                $urandom_range(7) == 0);
        made++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: threshold 3, base 2, cap 16, all anchors in use.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_req(15, 1, 1);
    add_req(0, 0, 0);
    add_req(0, 0, 0);
    add_req(0, 0, 0);
    add_req(0, 1, 0);
    add_req(0, 1, 0);
    add_req(0, 0, 0);
    add_req(0, 0, 0);
    add_req(0, 0, 0);
    add_req(0, 1, 1);
    add_req(1, 0, 0);
    add_req(1, 1, 0);
    add_req(2, 0, 1);
    add_req(2, 1, 0);
    add_req(7, 1, 0);
    add_req(8, 1, 0);
    add_req(15, 0, 0);
    wait_drained();

    setup_phase(16, 3, 2, 16, IDLE_NONE);
    gen_traffic(150, 60, 70);
    wait_drained();
    gen_traffic(150, 60, 70);
    wait_drained();

    setup_phase(16, 1, 1, 255, IDLE_SEND);
    gen_traffic(250, 50, 70);
    wait_drained();

    // Zero threshold and zero cap: every failure starts an empty backoff.
    setup_phase(5, 0, 31, 0, IDLE_RECV);
    gen_traffic(200, 50, 60);
    wait_drained();

    setup_phase(0, 255, 1, 1, IDLE_BOTH);
    gen_traffic(60, 50, 50);
    wait_drained();

    setup_phase(16, 2, 31, 255, IDLE_BOTH);
    gen_traffic(200, 80, 70);
    wait_drained();

    setup_phase(11, 4, 3, 20, IDLE_SEND);
    gen_traffic(200, 70, 70);
    wait_drained();

    // Highest threshold, then mostly good ranging with rare sweep starts
    // so that the good count saturates.
    setup_phase(16, 255, 5, 100, IDLE_RECV);
    for (int i = 0; i < 256; i++) add_req(3, 0, 0);
    gen_traffic(200, 5, 30);
    wait_drained();

    setup_phase(1, 1, 31, 7, IDLE_NONE);
    gen_traffic(200, 50, 50);
    wait_drained();

    repeat (10) @(posedge clk);
    if (err_cnt == 0 && slot_expect.size() == 0) begin
      $display("tb_anchor_failure_backoff_table passed");
    end else begin
      $display("tb_anchor_failure_backoff_table failed");
    end
    $finish;
  end

endmodule
